/* sv/dust_density_estimator_unit_macros.svh */
// Assertion macros used by the checker file.
`ifndef DUST_DENSITY_ESTIMATOR_UNIT_MACROS_SVH
`define DUST_DENSITY_ESTIMATOR_UNIT_MACROS_SVH

// Same-cycle implication.
`define DDE_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DDE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Check without reset qualifier.
`define DDE_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/dde_pkg.sv */
// ----------------------------------------------------------------------------
// dde_pkg
// Types and constants of the dust density estimator.
// ----------------------------------------------------------------------------
package dde_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLES   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REF_MV    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SENS_MV   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_MV   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ZLOW_MV   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ZHIGH_MV  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 3'd7;

  localparam int MV_REG_W = 13;
  localparam int ADC_BITS = 10;

  typedef struct packed {
    logic [ADC_BITS-1:0] raw_sample;
    logic                take_baseline;
  } in_t;

  typedef struct packed {
    logic [15:0]         density;
    logic [15:0]         running_average;
    logic [15:0]         burst_mv;
    logic [MV_REG_W-1:0] candidate_mv;
    logic                candidate_ready;
  } out_t;

endpackage

/* sv/dust_density_estimator_unit.sv */
// ----------------------------------------------------------------------------
// dust_density_estimator_unit
// Burst averaging of ADC samples, mV scaling, dust density and running mean.
// ----------------------------------------------------------------------------
// Usage:
//   in_data carries one ADC sample and the take_baseline flag per item.
//   A sample that does not end a burst is added to the burst sum and gives no
//   result. The sample that ends a burst starts the result sequence, during
//   which in_stall is high:
//     burst mean divide, multiply by reference, multiply by gain, scale,
//     density setup, density divide when needed, ring write, ring scan of
//     the filled entries in the window, mean divide when needed, result.
//   With the window off, the scan and the mean divide are skipped. A single
//   restoring divider is shared by all three divides, and the ring scan reads
//   one entry per cycle. The ring RAM holds recent densities; the written
//   entries always form a prefix, so a fill count stands for valid bits.
//   One result item leaves on out_data per burst. The result waits in the
//   output register while out_stall is high; samples keep being accepted,
//   and the next burst end holds until that register is free.
//   Reset (rst, synchronous) restores the register defaults and empties the
//   ring at once; no clearing pass is needed.
//   Configuration writes (cfg_wr_en) take effect in the next cycle.
// ----------------------------------------------------------------------------
module dust_density_estimator_unit #(
  parameter int RING_DEPTH   = 64,
  parameter int MIN_READINGS = 60
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [dde_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dde_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  dde_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output dde_pkg::out_t                  out_data
);

  localparam int PW    = RING_DEPTH > 1 ? $clog2(RING_DEPTH) : 1;
  localparam int LW    = $clog2(RING_DEPTH + 1);
  localparam int CW    = LW > 7 ? LW : 7;
  localparam int SW    = 16 + LW;
  localparam int AVG_W = 18;
  localparam int P1_W  = AVG_W + 13;
  localparam int P2_W  = P1_W + 16;
  localparam int SHIFT = dde_pkg::ADC_BITS + 8;
  localparam int MV_W  = P2_W - SHIFT;
  localparam int DQ_W  = 40;
  localparam int DR_W  = 16;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_MUL1, S_MUL2, S_MV, S_DEN, S_WRITE, S_SCAN, S_OUT
  } state_t;

  typedef enum logic [1:0] {DS_AVG, DS_DEN, DS_MEAN} div_sel_t;

  state_t   state;
  div_sel_t div_sel;

  // configuration
  logic [7:0]  samples_per_burst;
  logic [12:0] reference_mv, sensitivity_mv, baseline_mv, zero_low_mv, zero_high_mv;
  logic [15:0] calibration_gain;
  logic [6:0]  window_length;

  // burst and tracker state
  logic [7:0]  burst_count;
  logic [17:0] burst_sum;
  logic [12:0] min_tracker_mv, held_candidate_mv;
  logic [15:0] reading_count;
  logic        ready_flag;
  logic        take;
  logic [LW-1:0] ring_pointer, fill;

  // datapath
  logic [DQ_W-1:0] div_q;
  logic [DR_W-1:0] div_r, div_d;
  logic [5:0]      div_cnt;
  logic [AVG_W-1:0] avg;
  logic [P1_W-1:0] p1;
  logic [P2_W-1:0] p2;
  logic [MV_W-1:0] mv;
  logic [15:0]     density, mean;
  logic [12:0]     cand;
  logic            ready_o;
  logic [LW-1:0]   scan_idx, scan_len;
  logic            acc_en;
  logic [SW-1:0]   scan_sum;

  logic [7:0]      n, count_new;
  logic [17:0]     sum_new;
  logic [DR_W+1:0] trial;
  logic [DR_W-1:0] r_next;
  logic [DQ_W-1:0] q_next;
  logic [LW-1:0]   len, wp, pn, fill_new, scan_len_new;
  logic [15:0]     rc_new;
  logic            ready_new;
  logic [12:0]     min_new;
  logic [15:0]     rd_data;
  logic            ram_we;
  logic [MV_W-1:0] mv_ext_min, mv_ext_lo, mv_ext_hi, mv_ext_base;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    n         = (samples_per_burst == 8'd0) ? 8'd1 : samples_per_burst;
    sum_new   = burst_sum + 18'(in_data.raw_sample);
    count_new = burst_count + 8'd1;

    trial  = {1'b0, div_r, div_q[DQ_W-1]} - {2'b00, div_d};
    r_next = trial[DR_W+1] ? {div_r[DR_W-2:0], div_q[DQ_W-1]} : trial[DR_W-1:0];
    q_next = {div_q[DQ_W-2:0], ~trial[DR_W+1]};

    if (CW'(window_length) > CW'(RING_DEPTH)) begin
      len = LW'(RING_DEPTH);
    end else begin
      len = LW'(window_length);
    end
    wp       = (ring_pointer >= len) ? '0 : ring_pointer;
    pn       = wp + LW'(1);
    fill_new = (pn > fill) ? pn : fill;
    scan_len_new = (fill_new < len) ? fill_new : len;

    rc_new    = reading_count;
    ready_new = ready_flag;
    if (!ready_flag) begin
      if (reading_count != 16'hFFFF) begin
        rc_new = reading_count + 16'd1;
      end
      ready_new = (32'(rc_new) > 32'(MIN_READINGS));
    end

    mv_ext_min  = MV_W'(min_tracker_mv);
    mv_ext_lo   = MV_W'(zero_low_mv);
    mv_ext_hi   = MV_W'(zero_high_mv);
    mv_ext_base = MV_W'(baseline_mv);
    min_new = min_tracker_mv;
    if (mv < mv_ext_min && mv >= mv_ext_lo && mv <= mv_ext_hi) begin
      min_new = mv[12:0];
    end

    ram_we = (state == S_WRITE) && (len != '0);
  end

  dde_ram #(.WIDTH(16), .DEPTH(RING_DEPTH)) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp[PW-1:0]),
    .wdata (density),
    .raddr (scan_idx[PW-1:0]),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      div_sel           <= DS_AVG;
      samples_per_burst <= 8'd20;
      reference_mv      <= 13'd5000;
      calibration_gain  <= 16'd256;
      sensitivity_mv    <= 13'd500;
      baseline_mv       <= 13'd600;
      zero_low_mv       <= 13'd100;
      zero_high_mv      <= 13'd1100;
      window_length     <= 7'd60;
      burst_count       <= '0;
      burst_sum         <= '0;
      min_tracker_mv    <= 13'd600;
      held_candidate_mv <= 13'd600;
      reading_count     <= '0;
      ready_flag        <= 1'b0;
      ring_pointer      <= '0;
      fill              <= '0;
      out_valid         <= 1'b0;
      acc_en            <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          dde_pkg::REG_SAMPLES:  samples_per_burst <= cfg_data[7:0];
          dde_pkg::REG_REF_MV:   reference_mv      <= cfg_data[12:0];
          dde_pkg::REG_GAIN:     calibration_gain  <= cfg_data;
          dde_pkg::REG_SENS_MV:  sensitivity_mv    <= cfg_data[12:0];
          dde_pkg::REG_BASE_MV:  baseline_mv       <= cfg_data[12:0];
          dde_pkg::REG_ZLOW_MV:  zero_low_mv       <= cfg_data[12:0];
          dde_pkg::REG_ZHIGH_MV: zero_high_mv      <= cfg_data[12:0];
          dde_pkg::REG_WINDOW:   window_length     <= cfg_data[6:0];
          default: ;
        endcase
      end

      // S_OUT reloads the register itself when it frees up
      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (count_new >= n) begin
              burst_sum   <= '0;
              burst_count <= '0;
              take        <= in_data.take_baseline;
              div_q       <= DQ_W'(sum_new);
              div_r       <= '0;
              div_d       <= DR_W'(n);
              div_cnt     <= '0;
              div_sel     <= DS_AVG;
              state       <= S_DIV;
            end else begin
              burst_sum   <= sum_new;
              burst_count <= count_new;
            end
          end
        end
        S_DIV: begin
          div_q   <= q_next;
          div_r   <= r_next;
          div_cnt <= div_cnt + 6'd1;
          if (div_cnt == 6'(DQ_W - 1)) begin
            case (div_sel)
              DS_AVG: begin
                avg   <= q_next[AVG_W-1:0];
                state <= S_MUL1;
              end
              DS_DEN: begin
                density <= (|q_next[DQ_W-1:16]) ? 16'hFFFF : q_next[15:0];
                state   <= S_WRITE;
              end
              default: begin
                mean  <= (|q_next[DQ_W-1:16]) ? 16'hFFFF : q_next[15:0];
                state <= S_OUT;
              end
            endcase
          end
        end
        S_MUL1: begin
          p1    <= P1_W'(avg) * P1_W'(reference_mv);
          state <= S_MUL2;
        end
        S_MUL2: begin
          p2    <= P2_W'(p1) * P2_W'(calibration_gain);
          state <= S_MV;
        end
        S_MV: begin
          mv    <= p2[P2_W-1:SHIFT];
          state <= S_DEN;
        end
        S_DEN: begin
          min_tracker_mv <= min_new;
          if (mv < mv_ext_base) begin
            density <= '0;
            state   <= S_WRITE;
          end else if (sensitivity_mv == 13'd0) begin
            density <= 16'hFFFF;
            state   <= S_WRITE;
          end else begin
            div_q   <= DQ_W'(mv - mv_ext_base) * DQ_W'(100);
            div_r   <= '0;
            div_d   <= DR_W'(sensitivity_mv);
            div_cnt <= '0;
            div_sel <= DS_DEN;
            state   <= S_DIV;
          end
        end
        S_WRITE: begin
          if (len != '0) begin
            ring_pointer <= (pn >= len) ? '0 : pn;
            fill         <= fill_new;
          end
          ready_o       <= ready_new;
          cand          <= ready_new ? min_tracker_mv : held_candidate_mv;
          // consume the candidate once it has been reported
          if (take && ready_new) begin
            min_tracker_mv    <= zero_high_mv;
            held_candidate_mv <= zero_high_mv;
            reading_count     <= '0;
            ready_flag        <= 1'b0;
          end else begin
            reading_count <= rc_new;
            ready_flag    <= ready_new;
          end
          scan_idx <= '0;
          scan_sum <= '0;
          acc_en   <= 1'b0;
          scan_len <= (len != '0) ? scan_len_new : '0;
          if (len == '0) begin
            mean  <= 16'hFFFF;
            state <= S_OUT;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (acc_en) begin
            scan_sum <= scan_sum + SW'(rd_data);
          end
          if (scan_idx < scan_len) begin
            scan_idx <= scan_idx + LW'(1);
            acc_en   <= 1'b1;
          end else begin
            acc_en <= 1'b0;
            if (!acc_en) begin
              div_q   <= DQ_W'(scan_sum) + DQ_W'(scan_len >> 1);
              div_r   <= '0;
              div_d   <= DR_W'(scan_len);
              div_cnt <= '0;
              div_sel <= DS_MEAN;
              if (scan_len == '0) begin
                mean  <= '0;
                state <= S_OUT;
              end else begin
                state <= S_DIV;
              end
            end
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid                <= 1'b1;
            out_data.density         <= density;
            out_data.running_average <= mean;
            out_data.burst_mv        <= (|mv[MV_W-1:16]) ? 16'hFFFF : mv[15:0];
            out_data.candidate_mv    <= cand;
            out_data.candidate_ready <= ready_o;
            state                    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* sv/dde_ram.sv */
// ----------------------------------------------------------------------------
// dde_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dde_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/dde_checker.sv */
// ----------------------------------------------------------------------------
// dde_checker
// Port-level checks of the dust density estimator.
// ----------------------------------------------------------------------------
`include "dust_density_estimator_unit_macros.svh"

module dde_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input dde_pkg::out_t out_data
);

  `DDE_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
  `DDE_ASSERT_ALWAYS(a_rst_clear, clk, rst, !out_valid, "result valid after reset")
  `DDE_ASSERT_IMPL(a_res_busy, clk, rst, $rose(out_valid), $past(in_stall), "result without busy phase")
  `DDE_ASSERT_NEXT(a_busy_no_res, clk, rst, !out_valid && !in_stall, !out_valid, "result without burst end")
  `DDE_ASSERT_NEXT(a_idle_stays, clk, rst, !in_valid && !in_stall, !in_stall, "busy without an item")

endmodule

bind dust_density_estimator_unit dde_checker u_dde_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
